### src/mchw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mchw_pkg;

	// Command codes
	localparam logic [2:0] CMD_REGISTER   = 3'd0;
	localparam logic [2:0] CMD_UNREGISTER = 3'd1;
	localparam logic [2:0] CMD_KICK       = 3'd2;
	localparam logic [2:0] CMD_CHECK      = 3'd3;
	localparam logic [2:0] CMD_QUERY      = 3'd4;

	// Priority classes
	localparam logic [2:0] CLS_CRITICAL   = 3'd0;
	localparam logic [2:0] CLS_HIGH       = 3'd1;
	localparam logic [2:0] CLS_STANDARD   = 3'd2;
	localparam logic [2:0] CLS_LOW        = 3'd3;
	localparam logic [2:0] CLS_BACKGROUND = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] REG_WATCH_ENABLED  = 3'd0;
	localparam logic [2:0] REG_CHECK_INTERVAL = 3'd1;
	localparam logic [2:0] REG_AUTO_RESTART   = 3'd2;
	localparam logic [2:0] REG_HANDLER        = 3'd3;
	localparam logic [2:0] REG_CRIT_TIMEOUT   = 3'd4;
	localparam logic [2:0] REG_STD_TIMEOUT    = 3'd5;
	localparam logic [2:0] REG_BG_TIMEOUT     = 3'd6;

	localparam logic [6:0] SCORE_FULL    = 7'd100;
	localparam logic [6:0] SCORE_HEALTHY = 7'd80;
	localparam logic [2:0] COUNT_MAX     = 3'd7;

	// Timeout for a class; unknown classes fall back to the standard timeout.
	function automatic logic [31:0] class_timeout(input logic [2:0] cls,
		input logic [30:0] crit, input logic [30:0] std, input logic [30:0] bg);
		logic [31:0] t;
		unique case (cls)
			CLS_CRITICAL:   t = {1'b0, crit};
			CLS_HIGH:       t = {crit, 1'b0};
			CLS_STANDARD:   t = {1'b0, std};
			CLS_LOW:        t = {std, 1'b0};
			CLS_BACKGROUND: t = {1'b0, bg};
			default:        t = {1'b0, std};
		endcase
		return t;
	endfunction

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture input word
		logic apply_cmd;  // perform register, unregister, kick or query
		logic sweep_init; // clear sweep accumulators
		logic sweep_step; // process one slot
		logic div_init;   // start the score division
		logic div_step;   // one quotient bit
		logic finish;     // commit score and check time
		logic out_load;   // present the result word
	} mchw_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_check;
		logic check_due;
		logic sweep_last;
		logic div_last;
	} mchw_stat_t;

endpackage
`default_nettype wire

### src/mchw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mchw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire logic               out_busy,
	input  wire mchw_pkg::mchw_stat_t st,
	output mchw_pkg::mchw_cmd_t     cmd,
	output logic                    in_ready
);
	import mchw_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEC   = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_fire;
				if (in_fire) state_d = ST_DEC;
			end
			ST_DEC: begin
				if (st.is_check && st.check_due) begin
					cmd.sweep_init = 1'b1;
					state_d = ST_SWEEP;
				end else begin
					cmd.apply_cmd = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_last) begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

### src/mchw_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mchw_dp #(
	parameter int NUM_SLOTS    = 16,
	parameter int MAX_ATTEMPTS = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mchw_pkg::mchw_cmd_t cmd,
	output mchw_pkg::mchw_stat_t     st,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic [2:0]          in_cmd,
	input  wire logic [3:0]          in_slot,
	input  wire logic [2:0]          in_class,
	input  wire logic [31:0]         in_now,
	input  wire logic [15:0]         in_ok,
	output logic [191:0]             result
);
	import mchw_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam logic [2:0] MAX_A = 3'(MAX_ATTEMPTS);

	// Configuration registers
	logic        watch_en_q, auto_restart_q, handler_q;
	logic [31:0] interval_q;
	logic [30:0] crit_q, std_q, bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_en_q <= 1'b1; auto_restart_q <= 1'b1; handler_q <= 1'b1;
			interval_q <= 32'd1000; crit_q <= 31'd1000; std_q <= 31'd5000;
			bg_q <= 31'd30000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WATCH_ENABLED:  watch_en_q <= cfg_data[0];
				REG_CHECK_INTERVAL: interval_q <= cfg_data;
				REG_AUTO_RESTART:   auto_restart_q <= cfg_data[0];
				REG_HANDLER:        handler_q <= cfg_data[0];
				REG_CRIT_TIMEOUT:   crit_q <= cfg_data[30:0];
				REG_STD_TIMEOUT:    std_q <= cfg_data[30:0];
				REG_BG_TIMEOUT:     bg_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Captured input word
	logic [2:0]  cmd_q, cls_q;
	logic [3:0]  slot_q;
	logic [31:0] now_q;
	logic [15:0] ok_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd; slot_q <= in_slot; cls_q <= in_class;
			now_q <= in_now; ok_q <= in_ok;
		end
	end

	// Slot table
	logic [NUM_SLOTS-1:0] valid_q, active_q;
	logic [2:0]  class_q [NUM_SLOTS];
	logic [31:0] kick_q  [NUM_SLOTS];
	logic [2:0]  count_q [NUM_SLOTS];

	// Global state
	logic [31:0] last_check_q, sweeps_q, good_q, bad_q, longest_q;
	logic [6:0]  score_q;

	// Sweep state
	logic [SW-1:0] idx_q;
	logic [CW-1:0] n_active_q, n_healthy_q;
	logic [15:0]   unresp_q, rmask_q;

	// Score division: healthy*100 / active, restoring, one bit a step.
	logic [13:0] dividend_q;
	logic [6:0]  quot_q;
	logic [CW:0] rem_q;
	logic [3:0]  dbit_q;
	logic        any_active_q;

	logic in_table;
	logic [SW-1:0] sidx;
	assign in_table = ({28'd0, slot_q} < 32'(NUM_SLOTS));
	assign sidx = SW'(slot_q);

	// Current sweep slot evaluation
	logic [31:0] quiet, tmo;
	logic        overdue;
	logic [2:0]  cnt_new;
	assign quiet   = now_q - kick_q[idx_q];
	assign tmo     = class_timeout(class_q[idx_q], crit_q, std_q, bg_q);
	assign overdue = quiet > tmo;
	assign cnt_new = (count_q[idx_q] < COUNT_MAX) ? count_q[idx_q] + 3'd1 : count_q[idx_q];

	// Query evaluation
	logic [31:0] q_quiet, q_tmo;
	assign q_quiet = now_q - kick_q[sidx];
	assign q_tmo   = class_timeout(class_q[sidx], crit_q, std_q, bg_q);

	assign st.is_check  = (cmd_q == CMD_CHECK);
	assign st.check_due = watch_en_q && ((now_q - last_check_q) >= interval_q);
	assign st.sweep_last = ({{(32-SW){1'b0}}, idx_q} == 32'(NUM_SLOTS - 1));
	assign st.div_last  = (dbit_q == 4'd0);

	logic [CW:0] rem_sh;
	assign rem_sh = {rem_q[CW-1:0], dividend_q[dbit_q]};

	// Slot table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; active_q <= '0;
		end else if (cmd.apply_cmd && in_table) begin
			if (cmd_q == CMD_REGISTER) begin
				valid_q[sidx] <= 1'b1; active_q[sidx] <= 1'b1;
			end else if (cmd_q == CMD_UNREGISTER) begin
				valid_q[sidx] <= 1'b0; active_q[sidx] <= 1'b0;
			end
		end else if (cmd.sweep_step && active_q[idx_q] && overdue) begin
			if (auto_restart_q && cnt_new <= MAX_A) begin
				if (handler_q && !ok_q[idx_q] && cnt_new >= MAX_A)
					active_q[idx_q] <= 1'b0;
			end else if (cnt_new > MAX_A) begin
				active_q[idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply_cmd && in_table) begin
			if (cmd_q == CMD_REGISTER) begin
				class_q[sidx] <= cls_q; kick_q[sidx] <= now_q; count_q[sidx] <= 3'd0;
			end else if (cmd_q == CMD_KICK && valid_q[sidx]) begin
				kick_q[sidx] <= now_q;
			end
		end else if (cmd.sweep_step && active_q[idx_q] && overdue) begin
			count_q[idx_q] <= cnt_new;
			if (auto_restart_q && cnt_new <= MAX_A && handler_q && ok_q[idx_q])
				kick_q[idx_q] <= now_q;
		end
	end

	// Sweep, division and global counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_check_q <= '0; sweeps_q <= '0; good_q <= '0; bad_q <= '0;
			longest_q <= '0; score_q <= SCORE_FULL;
			idx_q <= '0; n_active_q <= '0; n_healthy_q <= '0;
			unresp_q <= '0; rmask_q <= '0;
			dividend_q <= '0; quot_q <= '0; rem_q <= '0; dbit_q <= '0;
			any_active_q <= 1'b0;
		end else begin
			if (cmd.sweep_init) begin
				idx_q <= '0; n_active_q <= '0; n_healthy_q <= '0;
				unresp_q <= '0; rmask_q <= '0;
				sweeps_q <= sweeps_q + 32'd1;
			end
			if (cmd.sweep_step) begin
				idx_q <= idx_q + SW'(1);
				if (active_q[idx_q]) begin
					n_active_q <= n_active_q + CW'(1);
					if (!overdue) begin
						n_healthy_q <= n_healthy_q + CW'(1);
						if (quiet > longest_q) longest_q <= quiet;
					end else begin
						unresp_q[idx_q] <= 1'b1;
						if (auto_restart_q && cnt_new <= MAX_A && handler_q) begin
							rmask_q[idx_q] <= 1'b1;
							if (ok_q[idx_q]) good_q <= good_q + 32'd1;
							else bad_q <= bad_q + 32'd1;
						end
					end
				end
			end
			if (cmd.div_init) begin
				// Counts are final only after this step's update; include it here.
				dividend_q <= 14'(({7'd0, 7'(n_healthy_q)}
					+ ((active_q[idx_q] && !overdue) ? 14'd1 : 14'd0)) * 14'd100);
				rem_q <= '0;
				quot_q <= '0;
				dbit_q <= 4'd13;
			end
			if (cmd.div_step) begin
				dbit_q <= dbit_q - 4'd1;
				if (rem_sh >= {1'b0, n_active_q}) begin
					rem_q <= rem_sh - {1'b0, n_active_q};
					quot_q <= {quot_q[5:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quot_q <= {quot_q[5:0], 1'b0};
				end
			end
			if (cmd.finish) begin
				score_q <= (n_active_q != '0) ? quot_q : SCORE_FULL;
				last_check_q <= now_q;
			end
		end
	end

	// Final active count must include the last slot before division starts.
	// The divisor is read only in div_step, after the last sweep step landed.
	// The dividend needs the same correction, applied in div_init above.

	// Result word
	logic        alive;
	logic [2:0]  rcount;
	always_comb begin
		alive = 1'b0;
		rcount = 3'd0;
		if (cmd_q == CMD_QUERY && in_table && valid_q[sidx]) begin
			rcount = count_q[sidx];
			alive = active_q[sidx] && (q_quiet <= q_tmo);
		end
	end

	logic chk_q;
	always_ff @(posedge clk) begin
		if (cmd.sweep_init) chk_q <= 1'b1;
		else if (cmd.apply_cmd) chk_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result <= {19'd0, longest_q, bad_q, good_q, sweeps_q,
				rcount, alive, (score_q >= SCORE_HEALTHY), score_q,
				chk_q ? rmask_q : 16'd0, chk_q ? unresp_q : 16'd0, chk_q};
		end
	end
endmodule
`default_nettype wire

### src/multi_channel_heartbeat_watchdog.sv
`timescale 1ns / 1ps
`default_nettype none
// Heartbeat watchdog over NUM_SLOTS client slots. Each input word carries a
// command (register, unregister, kick, check, query) and the millisecond time;
// each yields one result word. A due check walks the slot table one slot per
// cycle and then forms the health score with a one-bit-per-cycle restoring
// divider. The result waits in an output register; a new word is taken once
// the previous one has moved there.
module multi_channel_heartbeat_watchdog #(
	parameter int NUM_SLOTS    = 16,
	parameter int MAX_ATTEMPTS = 3
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// cmd[2:0], slot[6:3], module_class[9:7], now_ms[41:10],
	// restart_ok_mask[57:42], zero fill [63:58]
	input  wire logic [63:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// check_done[0], unresponsive_mask[16:1], restart_mask[32:17],
	// health_score[39:33], system_healthy[40], module_alive[41],
	// module_restarts[44:42], sweep count[76:45], good restart count[108:77],
	// bad restart count[140:109], longest_quiet_ms[172:141], zero fill [175:173]
	output logic [175:0]      m_tdata
);
	import mchw_pkg::*;

	mchw_cmd_t  cmd;
	mchw_stat_t st;
	logic       in_fire, out_busy;
	logic [191:0] result;

	assign in_fire  = s_tvalid && s_tready;
	assign out_busy = m_tvalid && !m_tready;
	assign m_tdata  = result[175:0];

	mchw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_busy(out_busy),
		.st(st), .cmd(cmd), .in_ready(s_tready)
	);

	mchw_dp #(.NUM_SLOTS(NUM_SLOTS), .MAX_ATTEMPTS(MAX_ATTEMPTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_cmd(s_tdata[2:0]), .in_slot(s_tdata[6:3]), .in_class(s_tdata[9:7]),
		.in_now(s_tdata[41:10]), .in_ok(s_tdata[57:42]), .result(result)
	);

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (cmd.out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
endmodule
`default_nettype wire

### dv/tb_multi_channel_heartbeat_watchdog.sv
`timescale 1ns / 1ps
module tb_multi_channel_heartbeat_watchdog;
	import mchw_pkg::*;

	localparam int SLOTS     = 16;
	localparam int ATTEMPTS  = 3;
	localparam int LIMIT     = 600000;
	localparam logic [2:0] CMD_UNUSED = 3'd5;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// Result word layout, highest field first.
	typedef struct packed {
		logic [2:0]  fill;
		logic [31:0] longest_quiet;
		logic [31:0] failed;
		logic [31:0] restarts_ok;
		logic [31:0] checks;
		logic [2:0]  restarts;
		logic        alive;
		logic        healthy;
		logic [6:0]  score;
		logic [15:0] restart_mask;
		logic [15:0] unresp_mask;
		logic        done;
	} watch_result_t;

	// Scoreboard: mirrors the watchdog state and holds the results still to come.
	class watchdog_scoreboard;
		bit          enabled, auto_rst, handler;
		logic [31:0] interval;
		logic [30:0] crit_tmo, std_tmo, bg_tmo;
		bit          valid_q[SLOTS], active_q[SLOTS];
		logic [2:0]  class_q[SLOTS], count_q[SLOTS];
		logic [31:0] kick_q[SLOTS];
		logic [31:0] check_time, sweeps, good, bad, longest;
		logic [6:0]  score;
		watch_result_t pending_results[$];
		int errors;

		function new();
			enabled = 1; interval = 1000; auto_rst = 1; handler = 1;
			crit_tmo = 1000; std_tmo = 5000; bg_tmo = 30000;
			foreach (valid_q[i]) begin
				valid_q[i] = 0; active_q[i] = 0; class_q[i] = 0; count_q[i] = 0; kick_q[i] = 0;
			end
			check_time = 0; sweeps = 0; good = 0; bad = 0; longest = 0; score = 100;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_WATCH_ENABLED:  enabled = val[0];
				REG_CHECK_INTERVAL: interval = val;
				REG_AUTO_RESTART:   auto_rst = val[0];
				REG_HANDLER:        handler = val[0];
				REG_CRIT_TIMEOUT:   crit_tmo = val[30:0];
				REG_STD_TIMEOUT:    std_tmo = val[30:0];
				REG_BG_TIMEOUT:     bg_tmo = val[30:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] timeout_of(logic [2:0] cls);
			case (cls)
				CLS_CRITICAL:   return {1'b0, crit_tmo};
				CLS_HIGH:       return {crit_tmo, 1'b0};
				CLS_STANDARD:   return {1'b0, std_tmo};
				CLS_LOW:        return {std_tmo, 1'b0};
				CLS_BACKGROUND: return {1'b0, bg_tmo};
				default:        return {1'b0, std_tmo};
			endcase
		endfunction

		// Apply one accepted input word and queue the result it yields.
		function void apply_word(logic [63:0] w);
			logic [2:0]  cmd, cls;
			logic [3:0]  s;
			logic [31:0] now, quiet;
			logic [15:0] ok;
			int unsigned nh, nact;
			watch_result_t r;
			cmd = w[2:0]; s = w[6:3]; cls = w[9:7]; now = w[41:10]; ok = w[57:42];
			r = '0;
			case (cmd)
				CMD_REGISTER: begin
					valid_q[s] = 1; active_q[s] = 1; class_q[s] = cls;
					kick_q[s] = now; count_q[s] = 0;
				end
				CMD_UNREGISTER: begin
					valid_q[s] = 0; active_q[s] = 0;
				end
				CMD_KICK: if (valid_q[s]) kick_q[s] = now;
				CMD_CHECK: if (enabled && (now - check_time) >= interval) begin
					r.done = 1;
					sweeps++;
					nh = 0; nact = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (!active_q[i]) continue;
						nact++;
						quiet = now - kick_q[i];
						if (quiet <= timeout_of(class_q[i])) begin
							nh++;
							if (quiet > longest) longest = quiet;
							continue;
						end
						r.unresp_mask[i] = 1;
						if (count_q[i] < COUNT_MAX) count_q[i]++;
						if (auto_rst && count_q[i] <= ATTEMPTS) begin
							if (handler) begin
								r.restart_mask[i] = 1;
								if (ok[i]) begin
									good++;
									kick_q[i] = now;
								end else begin
									bad++;
									if (count_q[i] >= ATTEMPTS) active_q[i] = 0;
								end
							end
						end else if (count_q[i] > ATTEMPTS) begin
							active_q[i] = 0;
						end
					end
					score = (nact > 0) ? 7'((nh * 100) / nact) : SCORE_FULL;
					check_time = now;
				end
				CMD_QUERY: if (valid_q[s]) begin
					r.restarts = count_q[s];
					r.alive = active_q[s] && ((now - kick_q[s]) <= timeout_of(class_q[s]));
				end
				default: ;
			endcase
			r.score = score;
			r.healthy = (score >= SCORE_HEALTHY);
			r.checks = sweeps; r.restarts_ok = good; r.failed = bad; r.longest_quiet = longest;
			pending_results.push_back(r);
		endfunction

		function void cmp(string f, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, f, e, a);
				errors++;
			end
		endfunction

		// Compare one result word with the oldest queued result.
		function void check_word(logic [175:0] d);
			watch_result_t a, e;
			a = d;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none actual %0h", $time, d);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			cmp("check_done", e.done, a.done);
			cmp("unresponsive_mask", e.unresp_mask, a.unresp_mask);
			cmp("restart_mask", e.restart_mask, a.restart_mask);
			cmp("health_score", e.score, a.score);
			cmp("system_healthy", e.healthy, a.healthy);
			cmp("module_alive", e.alive, a.alive);
			cmp("module_restarts", e.restarts, a.restarts);
			cmp("sweep_count", e.checks, a.checks);
			cmp("good_restart_count", e.restarts_ok, a.restarts_ok);
			cmp("bad_restart_count", e.failed, a.failed);
			cmp("longest_quiet_ms", e.longest_quiet, a.longest_quiet);
			cmp("zero_fill", e.fill, a.fill);
		endfunction
	endclass

	logic          clk;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_index = '0;
	logic [31:0]   cfg_data = '0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [63:0]   s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [175:0]  m_tdata;

	watchdog_scoreboard sb = new();
	bit          calm = 0;
	int          words_sent = 0;
	int          cycles = 0;
	logic [31:0] now_ms = 0;
	int          step_max = 400;

	multi_channel_heartbeat_watchdog uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_multi_channel_heartbeat_watchdog NOT OK");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off, and no stalls while calm.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (!hold_done && words_sent >= 60) begin
				hold_done = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata);
	end

	task automatic send_word(logic [2:0] cmd, logic [3:0] slot, logic [2:0] cls,
		logic [31:0] now, logic [15:0] ok);
		logic [63:0] w;
		w = {6'b0, ok, now, cls, slot, cmd};
		while (!calm && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		sb.apply_word(w);
		words_sent++;
	endtask

	// Let the block drain, then write one register.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	// Random word, weighted toward kick and check traffic.
	task automatic random_word();
		int pick;
		logic [2:0] cmd;
		pick = $urandom_range(0, 99);
		if (pick < 15) cmd = CMD_REGISTER;
		else if (pick < 20) cmd = CMD_UNREGISTER;
		else if (pick < 50) cmd = CMD_KICK;
		else if (pick < 80) cmd = CMD_CHECK;
		else if (pick < 95) cmd = CMD_QUERY;
		else cmd = CMD_UNUSED + 3'($urandom_range(0, 2));
		if ($urandom_range(0, 49) == 0) now_ms = $urandom;
		else now_ms = now_ms + $urandom_range(0, step_max);
		send_word(cmd, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), now_ms,
			16'($urandom));
	endtask

	task automatic random_run(int n);
		repeat (n) random_word();
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings.
		send_word(CMD_REGISTER, 4'd0, CLS_CRITICAL, 32'd0, 16'h0000);
		send_word(CMD_REGISTER, 4'd15, CLS_BACKGROUND, 32'd0, 16'h0000);
		send_word(CMD_REGISTER, 4'd5, 3'd7, 32'd0, 16'h0000);
		send_word(CMD_REGISTER, 4'd1, CLS_HIGH, 32'd0, 16'h0000);
		send_word(CMD_REGISTER, 4'd3, CLS_LOW, 32'd0, 16'h0000);
		send_word(CMD_REGISTER, 4'd2, CLS_STANDARD, 32'd0, 16'h0000);
		send_word(CMD_KICK, 4'd7, CLS_CRITICAL, 32'd100, 16'h0000);
		send_word(CMD_UNREGISTER, 4'd9, CLS_CRITICAL, 32'd200, 16'h0000);
		send_word(CMD_CHECK, 4'd0, CLS_CRITICAL, 32'd500, 16'hFFFF);
		send_word(CMD_QUERY, 4'd0, CLS_CRITICAL, 32'd500, 16'h0000);
		send_word(CMD_CHECK, 4'd0, CLS_CRITICAL, 32'd1500, 16'h0000);
		send_word(CMD_CHECK, 4'd0, CLS_CRITICAL, 32'd2600, 16'hFFFF);
		send_word(CMD_CHECK, 4'd0, CLS_CRITICAL, 32'd9000, 16'h0000);
		send_word(CMD_CHECK, 4'd0, CLS_CRITICAL, 32'd20000, 16'h0000);
		send_word(CMD_QUERY, 4'd0, CLS_CRITICAL, 32'd20000, 16'h0000);
		send_word(CMD_QUERY, 4'd15, CLS_CRITICAL, 32'd20000, 16'h0000);
		send_word(CMD_QUERY, 4'd9, CLS_CRITICAL, 32'd20000, 16'h0000);
		send_word(CMD_UNUSED, 4'd1, CLS_CRITICAL, 32'd20000, 16'hFFFF);
		send_word(CMD_UNUSED + 3'd1, 4'd2, CLS_CRITICAL, 32'd20000, 16'hFFFF);
		send_word(CMD_UNUSED + 3'd2, 4'd3, 3'd7, 32'hFFFFFFFF, 16'hFFFF);
		send_word(CMD_UNREGISTER, 4'd15, CLS_CRITICAL, 32'd20500, 16'h0000);
		send_word(CMD_QUERY, 4'd15, CLS_CRITICAL, 32'd20500, 16'h0000);
		send_word(CMD_KICK, 4'd0, CLS_CRITICAL, 32'd21000, 16'h0000);
		send_word(CMD_CHECK, 4'd0, CLS_CRITICAL, 32'd40000, 16'hFFFF);
		now_ms = 32'd40000;

		// Short timeouts so that slots go overdue often.
		write_reg(REG_CHECK_INTERVAL, 32'd200);
		write_reg(REG_CRIT_TIMEOUT, 32'd300);
		write_reg(REG_STD_TIMEOUT, 32'd800);
		write_reg(REG_BG_TIMEOUT, 32'd2000);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		random_run(110);

		// Zero interval and zero timeouts: every check sweeps.
		write_reg(REG_CHECK_INTERVAL, 32'd0);
		write_reg(REG_CRIT_TIMEOUT, 32'd0);
		write_reg(REG_STD_TIMEOUT, 32'd0);
		write_reg(REG_BG_TIMEOUT, 32'd0);
		step_max = 3;
		random_run(110);

		// No automatic restarts.
		write_reg(REG_CRIT_TIMEOUT, 32'd50);
		write_reg(REG_STD_TIMEOUT, 32'd120);
		write_reg(REG_BG_TIMEOUT, 32'd400);
		write_reg(REG_AUTO_RESTART, 32'd0);
		step_max = 150;
		random_run(110);

		// No restart handler, and no idling on either side.
		write_reg(REG_AUTO_RESTART, 32'd1);
		write_reg(REG_HANDLER, 32'd0);
		calm = 1;
		random_run(110);
		calm = 0;

		// Watch disabled.
		write_reg(REG_HANDLER, 32'd1);
		write_reg(REG_WATCH_ENABLED, 32'd0);
		random_run(120);

		// Largest interval and timeouts, time near the wrap point.
		write_reg(REG_WATCH_ENABLED, 32'd1);
		write_reg(REG_CHECK_INTERVAL, 32'hFFFFFFFF);
		write_reg(REG_CRIT_TIMEOUT, 32'h7FFFFFFF);
		write_reg(REG_STD_TIMEOUT, 32'h7FFFFFFF);
		write_reg(REG_BG_TIMEOUT, 32'h7FFFFFFF);
		now_ms = 32'hFFFFF000;
		step_max = 200;
		random_run(50);

		// Medium settings across the wrap point.
		write_reg(REG_CHECK_INTERVAL, 32'd100);
		write_reg(REG_CRIT_TIMEOUT, 32'd250);
		write_reg(REG_STD_TIMEOUT, 32'd600);
		write_reg(REG_BG_TIMEOUT, 32'd1500);
		now_ms = 32'hFFFFFC00;
		random_run(60);

		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_multi_channel_heartbeat_watchdog OK");
		else
			$display("tb_multi_channel_heartbeat_watchdog NOT OK");
		$finish;
	end

endmodule
